// ----- rtl/zigzag_row_reorder_assert.svh -----
// Assertion macros for the zigzag row reorder block.
// Expects clk and rst_n in the scope of each use.
`ifndef ZIGZAG_ROW_REORDER_ASSERT_SVH
`define ZIGZAG_ROW_REORDER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZZRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zigzag_row_reorder: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ZZRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zigzag_row_reorder: assertion failed");

`endif

// ----- rtl/zzrr_pkg.sv -----
// Shared constants for the zigzag row reorder block.
// No dependencies; used by the top level and its checker.
package zzrr_pkg;

  localparam int BYTE_W      = 8;
  localparam int ROWS_W      = 7;
  localparam int MAX_LEN_DEF = 64;

  // configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(1);

  // register indexes (paddr[APB_AW-1:2])
  localparam logic [APB_AW-3:0] REG_ROW_COUNT = '0;

endpackage

// ----- rtl/zigzag_row_reorder.sv -----
// Channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | tdata[7:0] byte, tlast end of string
// out     | out | out_tvalid/tready  | tdata[7:0] byte, tlast end, tuser[0] truncated
// cfg     | in  | APB, pready high   | reg 0 @ 0x0: row_count[6:0]
//
// Load: one byte per cycle into a MAX_LEN x 8 buffer memory, no results.
// Burst: after the last byte, one buffer read per cycle, so one result per
// cycle while out_tready keeps up; each read passes the memory read register
// and the output queue. Input is held off (in_tready low) while reads are issued.
// A stall on out_tready backs up a two-entry output queue, which throttles
// the read issue. Reset (rst_n, synchronous) clears control only; the buffer
// is never read before being written by the current string.
// Depends on zzrr_pkg.
module zigzag_row_reorder #(
  parameter int MAX_LEN = zzrr_pkg::MAX_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_byte
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] out_byte
  output logic                        out_tlast,
  output logic [0:0]                  out_tuser,  // [0] truncated
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [zzrr_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [zzrr_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [zzrr_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;   // buffer address
  localparam int CW   = $clog2(MAX_LEN + 1);                   // length / row count
  localparam int PERW = $clog2(2 * MAX_LEN);                   // period
  localparam int PW   = $clog2(3 * MAX_LEN);                   // position + step
  localparam int RW   = zzrr_pkg::ROWS_W;
  localparam int BW   = zzrr_pkg::BYTE_W;
  localparam int CMPW = (CW > RW) ? CW : RW;

  localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  typedef struct packed {
    logic [BW-1:0] data;
    logic          last;
    logic          trunc;
  } out_item_t;

  // ---------------- configuration ----------------
  logic [RW-1:0] row_count_r;
  logic          cfg_wr;
  logic          cfg_sel_rows;

  assign cfg_pready   = 1'b1;
  assign cfg_sel_rows = (cfg_paddr[zzrr_pkg::APB_AW-1:2] == zzrr_pkg::REG_ROW_COUNT);
  assign cfg_wr       = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= zzrr_pkg::ROWS_RESET;
    end else if (cfg_wr && cfg_sel_rows) begin
      row_count_r <= cfg_pwdata[RW-1:0];
    end
  end

  assign cfg_prdata = cfg_sel_rows ? zzrr_pkg::APB_DW'(row_count_r) : '0;

  // ---------------- load side ----------------
  logic          state_r;
  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic          in_acc;
  logic          room;
  logic [CW-1:0] len_fin;
  logic [RW-1:0] rows_eff;
  logic          linear;

  // burst parameters, latched when the last byte arrives
  logic [CW-1:0]   len_r;
  logic [CW-1:0]   rows_r;
  logic [PERW-1:0] period_r;
  logic            trunc_r;

  logic [BW-1:0] mem [MAX_LEN];

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid & in_tready;
  assign room      = (count_r < LEN_MAX);
  assign len_fin   = room ? (count_r + CW'(1)) : count_r;
  assign rows_eff  = (row_count_r == '0) ? RW'(1) : row_count_r;
  // one row, or fewer bytes than rows: string passes through unchanged
  assign linear    = (rows_eff == RW'(1)) || (CMPW'(len_fin) < CMPW'(rows_eff));

  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      mem[count_r[AW-1:0]] <= in_tdata[BW-1:0];
    end
  end

  // ---------------- burst address sequencer ----------------
  // Walks row by row. Edge rows step by the period; middle rows alternate
  // period-2r (down to up) and 2r (up to next down).
  logic [PW-1:0] pos_r;
  logic [CW-1:0] row_r;
  logic          up_r;
  logic          edge_row;
  logic [PW-1:0] two_r;
  logic [PW-1:0] step;
  logic [PW-1:0] cand;
  logic          in_rng;
  logic [CW-1:0] row_nx;
  logic          more_rows;
  logic          issue;
  logic          can_issue;

  logic [1:0]    fifo_cnt_r;
  logic          rd_pend_r;
  logic          pop;
  logic [1:0]    occ;

  assign edge_row  = (row_r == '0) || (row_r == rows_r - CW'(1));
  assign two_r     = PW'({row_r, 1'b0});
  assign step      = edge_row ? PW'(period_r)
                   : (up_r ? two_r : (PW'(period_r) - two_r));
  assign cand      = pos_r + step;
  assign in_rng    = (cand < PW'(len_r));
  assign row_nx    = row_r + CW'(1);
  assign more_rows = (row_nx < rows_r);

  // reads in flight plus queued results never exceed the queue depth
  assign pop       = out_tvalid & out_tready;
  assign occ       = fifo_cnt_r + 2'(rd_pend_r);
  assign can_issue = ((occ - 2'(pop)) < 2'd2);
  assign issue     = (state_r == ST_EMIT) && can_issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (in_tlast) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_EMIT;
            end else if (room) begin
              count_r <= count_r + CW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (issue && !in_rng && !more_rows) begin
            state_r <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      len_r    <= len_fin;
      trunc_r  <= ovf_r | ~room;
      rows_r   <= linear ? CW'(1) : CW'(rows_eff);
      period_r <= linear ? PERW'(1) : (PERW'({rows_eff, 1'b0}) - PERW'(2));
      pos_r    <= '0;
      row_r    <= '0;
      up_r     <= 1'b0;
    end else if (issue) begin
      if (in_rng) begin
        pos_r <= cand;
        up_r  <= ~up_r;
      end else if (more_rows) begin
        row_r <= row_nx;
        pos_r <= PW'(row_nx);
        up_r  <= 1'b0;
      end
    end
  end

  // ---------------- buffer read ----------------
  out_item_t rd_q_r;

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_q_r.data  <= mem[pos_r[AW-1:0]];
      rd_q_r.last  <= ~in_rng & ~more_rows;
      rd_q_r.trunc <= trunc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= issue;
    end
  end

  // ---------------- two-entry output queue ----------------
  out_item_t fifo_r [2];
  logic      wr_ptr_r;
  logic      rd_ptr_r;
  out_item_t head;

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      fifo_r[wr_ptr_r] <= rd_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      fifo_cnt_r <= '0;
    end else begin
      if (rd_pend_r) wr_ptr_r <= ~wr_ptr_r;
      if (pop)       rd_ptr_r <= ~rd_ptr_r;
      fifo_cnt_r <= fifo_cnt_r + 2'(rd_pend_r) - 2'(pop);
    end
  end

  assign head         = fifo_r[rd_ptr_r];
  assign out_tvalid   = (fifo_cnt_r != '0);
  assign out_tdata    = head.data;
  assign out_tlast    = head.last;
  assign out_tuser[0] = head.trunc;

endmodule

// ----- rtl/zzrr_checker.sv -----
// Port-level checker for zigzag_row_reorder, bound to the top level.
// Depends on zzrr_pkg and zigzag_row_reorder_assert.svh.
`include "zigzag_row_reorder_assert.svh"

module zzrr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        in_tlast,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [zzrr_pkg::BYTE_W-1:0] out_tdata,
  input logic                        out_tlast,
  input logic [0:0]                  out_tuser
);

  // a last byte always starts a burst, which holds off input
  `ZZRR_ASSERT_NEXT(a_last_blocks_input, in_tvalid && in_tready && in_tlast, !in_tready)

  // input is only held off right after a last byte was taken
  `ZZRR_ASSERT_NOW(a_block_cause, $fell(in_tready), $past(in_tvalid && in_tlast))

  // stalled result holds its payload
  `ZZRR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

endmodule

bind zigzag_row_reorder zzrr_checker u_zzrr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ----- tb/tb_zigzag_row_reorder.sv -----
// Self-checking testbench for zigzag_row_reorder: streams strings in, predicts
// the rail-fence order of each burst and checks every emitted character.
// Depends on zzrr_pkg and the zigzag_row_reorder RTL.
module tb_zigzag_row_reorder;

  localparam int CLK_HALF    = 10;
  localparam int TOTAL_ITEMS = 110;
  localparam logic [zzrr_pkg::APB_AW-1:0] ROWS_ADDR = {zzrr_pkg::REG_ROW_COUNT, 2'b00};

  // one emitted character as the block should produce it
  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
    logic       trunc;
  } zz_char_t;

  // Tracks the string buffer and row setting, and holds the characters
  // still owed by the block in emission order.
  class rail_fence_tracker;
    logic [7:0]                  char_buf [zzrr_pkg::MAX_LEN_DEF];
    int                          held;
    bit                          dropped;
    logic [zzrr_pkg::ROWS_W-1:0] rows_cfg;
    zz_char_t                    owed_q[$];
    int                          errors;

    function new();
      held     = 0;
      dropped  = 0;
      rows_cfg = zzrr_pkg::ROWS_RESET;
      errors   = 0;
    endfunction

    function void set_rows(input logic [zzrr_pkg::ROWS_W-1:0] v);
      rows_cfg = v;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void push_char(input int idx, input bit trn);
      zz_char_t c;
      c.ch    = char_buf[idx % zzrr_pkg::MAX_LEN_DEF];
      c.lst   = 1'b0;
      c.trunc = trn;
      owed_q.push_back(c);
    endfunction

    // accepted input transaction: store, and on the last mark queue the burst
    function void take_char(input logic [7:0] ch, input logic lst);
      int len, rows, period, first, r, j, k;
      bit trn;
      if (held < zzrr_pkg::MAX_LEN_DEF) begin
        char_buf[held] = ch;
        held++;
      end else begin
        dropped = 1;       // full: byte lost, last mark still counts
      end
      if (!lst) return;
      len   = held;
      rows  = (rows_cfg == 0) ? 1 : int'(rows_cfg);
      trn   = dropped;
      first = owed_q.size();
      if (rows == 1 || len < rows) begin
        for (k = 0; k < len; k++) push_char(k, trn);
      end else begin
        period = 2 * rows - 2;
        for (r = 0; r < rows; r++) begin
          for (j = 0; r + j * period < len; j++) begin
            push_char(r + j * period, trn);
            if (r != 0 && r != rows - 1) begin
              k = (j + 1) * period - r;
              if (k >= len) break;
              push_char(k, trn);
            end
          end
        end
      end
      if (owed_q.size() > first) owed_q[owed_q.size() - 1].lst = 1'b1;
      held    = 0;
      dropped = 0;
    endfunction

    // accepted output transaction: compare with the oldest owed character
    function void check_emitted(input logic [7:0] ch, input logic lst, input logic trn);
      zz_char_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result: byte %h last %b truncated %b",
                 $time, ch, lst, trn);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (want.ch !== ch) begin
        $display("%0t: byte expected %h actual %h", $time, want.ch, ch);
        errors++;
      end
      if (want.lst !== lst) begin
        $display("%0t: last expected %b actual %b", $time, want.lst, lst);
        errors++;
      end
      if (want.trunc !== trn) begin
        $display("%0t: truncated expected %b actual %b", $time, want.trunc, trn);
        errors++;
      end
    endfunction
  endclass

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_tvalid   = 1'b0;
  logic                        in_tready;
  logic [7:0]                  in_tdata    = '0;   // [7:0] in_byte
  logic                        in_tlast    = 1'b0;
  logic                        out_tvalid;
  logic                        out_tready  = 1'b0;
  logic [7:0]                  out_tdata;          // [7:0] out_byte
  logic                        out_tlast;
  logic [0:0]                  out_tuser;          // [0] truncated
  logic                        cfg_psel    = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite  = 1'b0;
  logic [zzrr_pkg::APB_AW-1:0] cfg_paddr   = '0;
  logic [zzrr_pkg::APB_DW-1:0] cfg_pwdata  = '0;
  logic [zzrr_pkg::APB_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  // idle rates in percent of cycles, changed per phase
  int in_idle_pct  = 28;
  int out_idle_pct = 74;

  // input transactions accepted so far
  int sent_items = 0;

  rail_fence_tracker sb = new();

  zigzag_row_reorder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // receiver: random backpressure at the current rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // monitors sample pre-edge values, so the order of processes does not matter
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.take_char(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready)
      sb.check_emitted(out_tdata, out_tlast, out_tuser[0]);
  end

  // one input transaction; an optional gap first, valid held through the stall
  task automatic send_char(input logic [7:0] ch, input logic lst);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    sent_items++;
  endtask

  task automatic send_string(input int len);
    for (int i = 0; i < len; i++)
      send_char(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // drop valid and wait for every owed character; the extra cycles cover the
  // memory read and output stage of the block
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic write_rows(input logic [zzrr_pkg::ROWS_W-1:0] v);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ROWS_ADDR;
    cfg_pwdata  <= zzrr_pkg::APB_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_rows(v);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    int len;
    int base;
    int pick;
    logic [zzrr_pkg::ROWS_W-1:0] rows_val;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset row count of one, zero and all-ones characters
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    // three rows, string longer than one full period
    write_rows(zzrr_pkg::ROWS_W'(3));
    send_string(7);
    // zero rows behaves as one row
    write_rows(zzrr_pkg::ROWS_W'(0));
    send_string(3);
    // more rows than characters: unchanged
    write_rows(zzrr_pkg::ROWS_W'(4));
    send_string(2);
    // two rows: no middle rows
    write_rows(zzrr_pkg::ROWS_W'(2));
    send_string(5);
    // all register bits set, far above the buffer size
    write_rows(zzrr_pkg::ROWS_W'(127));
    send_string(4);
    // overrun the buffer: dropped bytes, including a dropped last character
    write_rows(zzrr_pkg::ROWS_W'(5));
    send_string(66);

    // random short strings; sender-heavy idling first, then no idling
    base = sent_items;
    while (sent_items < TOTAL_ITEMS) begin
      if ((sent_items - base) * 2 < (TOTAL_ITEMS - base)) begin
        in_idle_pct  = 74;
        out_idle_pct = 28;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       rows_val = zzrr_pkg::ROWS_W'(0);
          1:       rows_val = zzrr_pkg::ROWS_W'(zzrr_pkg::MAX_LEN_DEF);
          2:       rows_val = zzrr_pkg::ROWS_W'(127);
          3:       rows_val = zzrr_pkg::ROWS_W'($urandom_range(1, zzrr_pkg::MAX_LEN_DEF));
          default: rows_val = zzrr_pkg::ROWS_W'($urandom_range(2, 8));
        endcase
        write_rows(rows_val);
      end
      len = $urandom_range(1, 8);
      send_string(len);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("zigzag_row_reorder: match");
    end else begin
      $display("zigzag_row_reorder: mismatch");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #(2 * CLK_HALF * 200000);
    $display("zigzag_row_reorder: mismatch");
    $finish;
  end

endmodule
